// ===== hdl/sif_pkg.sv =====
// Shared types for the segment intersection core.
package sif_pkg;

  // Status that travels with one beat through the range test and scaling stages.
  typedef struct packed {
    logic valid;
    logic ok;
  } div_stat_t;

endpackage

// ===== hdl/sif_divider.sv =====
// Pipelined signed restoring divider, one quotient bit per stage, truncating toward zero.
module sif_divider #(
  parameter int unsigned NUM_BITS = 40,
  parameter int unsigned DEN_BITS = 26,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [NUM_BITS-1:0] num_i,
  input  logic signed [DEN_BITS-1:0] den_i,
  input  logic        [TAG_BITS-1:0] tag_i,
  output logic                       valid_o,
  output logic signed [NUM_BITS-1:0] quot_o,
  output logic        [TAG_BITS-1:0] tag_o
);

  localparam int unsigned RW = DEN_BITS + 1;

  logic                valid_q [NUM_BITS+1];
  logic [NUM_BITS-1:0] quo_q   [NUM_BITS+1];
  logic [RW-1:0]       rem_q   [NUM_BITS+1];
  logic [DEN_BITS-1:0] den_q   [NUM_BITS+1];
  logic                neg_q   [NUM_BITS+1];
  logic [TAG_BITS-1:0] tag_q   [NUM_BITS+1];

  logic [NUM_BITS-1:0] num_mag;
  logic [DEN_BITS-1:0] den_mag;

  always_comb begin
    num_mag = num_i[NUM_BITS-1] ? NUM_BITS'(-num_i) : NUM_BITS'(num_i);
    den_mag = den_i[DEN_BITS-1] ? DEN_BITS'(-den_i) : DEN_BITS'(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q[0] <= num_mag;
    rem_q[0] <= '0;
    den_q[0] <= den_mag;
    neg_q[0] <= num_i[NUM_BITS-1] ^ den_i[DEN_BITS-1];
    tag_q[0] <= tag_i;
  end

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [RW-1:0]       trial;
    logic [RW:0]         diff;
    always_comb begin
      trial = {rem_q[s][RW-2:0], quo_q[s][NUM_BITS-1]};
      diff  = {1'b0, trial} - {2'b0, den_q[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= diff[RW] ? trial : diff[RW-1:0];
      quo_q[s+1] <= {quo_q[s][NUM_BITS-2:0], ~diff[RW]};
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = valid_q[NUM_BITS];
  assign tag_o   = tag_q[NUM_BITS];
  assign quot_o  = neg_q[NUM_BITS] ? -$signed(quo_q[NUM_BITS]) : $signed(quo_q[NUM_BITS]);

endmodule

// ===== hdl/segment_intersection_fixed_core.sv =====
// Top level of the fixed-point segment intersection core.
// Throughput: one beat per cycle; busy is tied low since the pipeline never stalls.
// The depth is set by the two parallel bit-per-stage dividers forming ua and ub.
// Reset clears the valid bits and status ok bits of the pipeline; other data registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module segment_intersection_fixed_core #(
  parameter int unsigned FRAC_BITS  = 14,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] seg_a_x1_i,
  input  logic signed [COORD_BITS-1:0] seg_a_y1_i,
  input  logic signed [COORD_BITS-1:0] seg_a_x2_i,
  input  logic signed [COORD_BITS-1:0] seg_a_y2_i,
  input  logic signed [COORD_BITS-1:0] seg_b_x1_i,
  input  logic signed [COORD_BITS-1:0] seg_b_y1_i,
  input  logic signed [COORD_BITS-1:0] seg_b_x2_i,
  input  logic signed [COORD_BITS-1:0] seg_b_y2_i,
  output logic                         result_valid_o,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] hit_x_o,
  output logic signed [COORD_BITS-1:0] hit_y_o
);

  // Differences take one extra bit, products of two differences twice that,
  // and a difference of two products one more.
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned NW  = CW + FRAC_BITS;
  // The tag carries A's first endpoint and direction down the divider.
  localparam int unsigned TW  = 2 * COORD_BITS + 2 * DW;
  localparam int unsigned UW  = FRAC_BITS + 2;
  localparam int unsigned MW  = UW + DW;

  assign busy = 1'b0;

  // Stage 1: differences.
  logic                 v1_q;
  logic signed [DW-1:0] adx_q, ady_q, bdx_q, bdy_q, ox_q, oy_q;
  logic [COORD_BITS-1:0] ax1_1_q, ay1_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q   <= DW'(seg_a_x2_i) - DW'(seg_a_x1_i);
    ady_q   <= DW'(seg_a_y2_i) - DW'(seg_a_y1_i);
    bdx_q   <= DW'(seg_b_x2_i) - DW'(seg_b_x1_i);
    bdy_q   <= DW'(seg_b_y2_i) - DW'(seg_b_y1_i);
    ox_q    <= DW'(seg_a_x1_i) - DW'(seg_b_x1_i);
    oy_q    <= DW'(seg_a_y1_i) - DW'(seg_b_y1_i);
    ax1_1_q <= seg_a_x1_i;
    ay1_1_q <= seg_a_y1_i;
  end

  // Stage 2: the six cross products, each a narrow multiply.
  logic                 v2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [TW-1:0]        tag2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= PW'(bdy_q) * PW'(adx_q);
    p1_q   <= PW'(bdx_q) * PW'(ady_q);
    p2_q   <= PW'(bdx_q) * PW'(oy_q);
    p3_q   <= PW'(bdy_q) * PW'(ox_q);
    p4_q   <= PW'(adx_q) * PW'(oy_q);
    p5_q   <= PW'(ady_q) * PW'(ox_q);
    tag2_q <= {ax1_1_q, ay1_1_q, adx_q, ady_q};
  end

  // Stage 3: denominator and numerators.
  logic                 v3_q;
  logic signed [CW-1:0] d_q, na_q, nb_q;
  logic [TW-1:0]        tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= CW'(p0_q) - CW'(p1_q);
    na_q   <= CW'(p2_q) - CW'(p3_q);
    nb_q   <= CW'(p4_q) - CW'(p5_q);
    tag3_q <= tag2_q;
  end

  // Dividers. A zero denominator yields a quotient that is ignored, since the
  // zero flag travels in the tag of the ub divider.
  logic signed [NW-1:0] na_sh, nb_sh;
  logic signed [NW-1:0] ua, ub;
  logic                 va, vb;
  logic [TW-1:0]        tag_a;
  logic [0:0]           tag_b;
  logic                 dz_b;

  assign na_sh = {na_q, {FRAC_BITS{1'b0}}};
  assign nb_sh = {nb_q, {FRAC_BITS{1'b0}}};

  sif_divider #(.NUM_BITS(NW), .DEN_BITS(CW), .TAG_BITS(TW)) u_div_a (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(na_sh), .den_i(d_q), .tag_i(tag3_q),
    .valid_o(va), .quot_o(ua), .tag_o(tag_a)
  );

  sif_divider #(.NUM_BITS(NW), .DEN_BITS(CW), .TAG_BITS(1)) u_div_b (
    .clk_i, .rst_ni, .valid_i(v3_q), .num_i(nb_sh), .den_i(d_q), .tag_i(d_q == '0),
    .valid_o(vb), .quot_o(ub), .tag_o(tag_b)
  );

  assign dz_b = tag_b[0];

  // Range test after the dividers.
  localparam logic signed [NW-1:0] OneQ = NW'(1) <<< FRAC_BITS;

  sif_pkg::div_stat_t   st4_q;
  logic signed [UW-1:0] ua4_q;
  logic [TW-1:0]        tag4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st4_q <= '0;
    end else begin
      st4_q.valid <= va & vb;
      st4_q.ok    <= !dz_b && !ua[NW-1] && ua <= OneQ && !ub[NW-1] && ub <= OneQ;
    end
  end

  always_ff @(posedge clk_i) begin
    ua4_q  <= UW'(ua);
    tag4_q <= tag_a;
  end

  // Scale the direction by ua.
  logic [COORD_BITS-1:0] ax1_4, ay1_4;
  logic signed [DW-1:0]  adx_4, ady_4;
  assign {ax1_4, ay1_4, adx_4, ady_4} = tag4_q;

  sif_pkg::div_stat_t    st5_q;
  logic signed [MW-1:0]  mx_q, my_q;
  logic [COORD_BITS-1:0] ax1_5_q, ay1_5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st5_q <= '0;
    end else begin
      st5_q <= st4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= MW'(ua4_q) * MW'(adx_4);
    my_q    <= MW'(ua4_q) * MW'(ady_4);
    ax1_5_q <= ax1_4;
    ay1_5_q <= ay1_4;
  end

  // Output register: arithmetic shift floors, then add A's first endpoint; coordinates are zero on a miss.
  logic signed [MW-1:0] sx, sy;
  assign sx = mx_q >>> FRAC_BITS;
  assign sy = my_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= st5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o   <= st5_q.ok;
    hit_x_o <= st5_q.ok ? ax1_5_q + sx[COORD_BITS-1:0] : '0;
    hit_y_o <= st5_q.ok ? ay1_5_q + sy[COORD_BITS-1:0] : '0;
  end

endmodule

// ===== test/segment_intersection_fixed_core_tb.sv =====
// Self-checking testbench for the fixed-point segment intersection core.
`timescale 1ns / 100ps

module segment_intersection_fixed_core_tb;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned COORD_BITS = 12;
  // An estimate of the depth from start beat to result strobe, plus slack for the final drain.
  localparam int unsigned PIPE_DEPTH = FRAC_BITS + 2 * COORD_BITS + 9;
  localparam int unsigned DRAIN_SLACK = PIPE_DEPTH + 20;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One segment pair as it goes into the core.
  typedef struct {
    coord_t ax1, ay1, ax2, ay2;
    coord_t bx1, by1, bx2, by2;
  } seg_pair_t;

  // One intersection answer as it comes out of the core.
  typedef struct {
    logic   hit;
    coord_t hx;
    coord_t hy;
  } crossing_t;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t seg_a_x1_i, seg_a_y1_i, seg_a_x2_i, seg_a_y2_i;
  coord_t seg_b_x1_i, seg_b_y1_i, seg_b_x2_i, seg_b_y2_i;
  logic   result_valid_o;
  logic   hit_o;
  coord_t hit_x_o, hit_y_o;

  // Answers predicted for beats already taken by the core, oldest first.
  crossing_t pending_crossings[$];
  int        error_count;
  int        sender_idle_pct;

  segment_intersection_fixed_core #(
    .FRAC_BITS (FRAC_BITS),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .seg_a_x1_i    (seg_a_x1_i),
    .seg_a_y1_i    (seg_a_y1_i),
    .seg_a_x2_i    (seg_a_x2_i),
    .seg_a_y2_i    (seg_a_y2_i),
    .seg_b_x1_i    (seg_b_x1_i),
    .seg_b_y1_i    (seg_b_y1_i),
    .seg_b_x2_i    (seg_b_x2_i),
    .seg_b_y2_i    (seg_b_y2_i),
    .result_valid_o(result_valid_o),
    .hit_o         (hit_o),
    .hit_x_o       (hit_x_o),
    .hit_y_o       (hit_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: this timeout is well beyond the slowest legal run.
  initial begin
    #400us;
    $display("CHECKS FAILED");
    $finish;
  end

  // Computes the crossing of two segments. The parameters ua and ub are formed in
  // Q-format with division truncating toward zero, and the point uses an
  // arithmetic right shift, which rounds toward minus infinity. Everything is
  // carried in 64 bits so that no intermediate wraps.
  function automatic crossing_t intersect_segments(seg_pair_t p);
    longint adx, ady, bdx, bdy, ox, oy, den, num_a, num_b, ua, ub, one_q;
    crossing_t c;
    one_q = longint'(1) << FRAC_BITS;
    adx   = longint'(p.ax2) - longint'(p.ax1);
    ady   = longint'(p.ay2) - longint'(p.ay1);
    bdx   = longint'(p.bx2) - longint'(p.bx1);
    bdy   = longint'(p.by2) - longint'(p.by1);
    ox    = longint'(p.ax1) - longint'(p.bx1);
    oy    = longint'(p.ay1) - longint'(p.by1);
    den   = bdy * adx - bdx * ady;
    num_a = bdx * oy - bdy * ox;
    num_b = adx * oy - ady * ox;
    c.hit = 1'b0;
    c.hx  = '0;
    c.hy  = '0;
    // Parallel and collinear pairs have a zero denominator and never hit.
    if (den != 0) begin
      ua = (num_a * one_q) / den;
      ub = (num_b * one_q) / den;
      if (ua >= 0 && ua <= one_q && ub >= 0 && ub <= one_q) begin
        c.hit = 1'b1;
        c.hx  = coord_t'(longint'(p.ax1) + ((ua * adx) >>> FRAC_BITS));
        c.hy  = coord_t'(longint'(p.ay1) + ((ua * ady) >>> FRAC_BITS));
      end
    end
    return c;
  endfunction

  // Records a prediction for every beat the core takes. Sampling at the clock
  // edge sees the values that were stable during the cycle before it.
  always @(posedge clk_i) begin
    seg_pair_t taken;
    if (rst_ni && start && !busy) begin
      taken.ax1 = seg_a_x1_i;
      taken.ay1 = seg_a_y1_i;
      taken.ax2 = seg_a_x2_i;
      taken.ay2 = seg_a_y2_i;
      taken.bx1 = seg_b_x1_i;
      taken.by1 = seg_b_y1_i;
      taken.bx2 = seg_b_x2_i;
      taken.by2 = seg_b_y2_i;
      pending_crossings.push_back(intersect_segments(taken));
    end
  end

  // Compares each strobed answer with the oldest prediction.
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_crossings.size() == 0) begin
        $error("result strobe with no beat outstanding");
        error_count++;
      end else begin
        want = pending_crossings.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit_o);
          error_count++;
        end
        if (hit_x_o !== want.hx) begin
          $error("hit_x: expected %0d, actual %0d", want.hx, hit_x_o);
          error_count++;
        end
        if (hit_y_o !== want.hy) begin
          $error("hit_y: expected %0d, actual %0d", want.hy, hit_y_o);
          error_count++;
        end
      end
    end
  end

  // Sends one segment pair, with random idle cycles ahead of it. The start line
  // is lowered only on idle cycles, so back-to-back beats keep it high.
  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    seg_a_x1_i <= p.ax1;
    seg_a_y1_i <= p.ay1;
    seg_a_x2_i <= p.ax2;
    seg_a_y2_i <= p.ay2;
    seg_b_x1_i <= p.bx1;
    seg_b_y1_i <= p.by1;
    seg_b_x2_i <= p.bx2;
    seg_b_y2_i <= p.by2;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic seg_pair_t make_pair(int ax1, int ay1, int ax2, int ay2,
                                          int bx1, int by1, int bx2, int by2);
    seg_pair_t p;
    p.ax1 = coord_t'(ax1);
    p.ay1 = coord_t'(ay1);
    p.ax2 = coord_t'(ax2);
    p.ay2 = coord_t'(ay2);
    p.bx1 = coord_t'(bx1);
    p.by1 = coord_t'(by1);
    p.bx2 = coord_t'(bx2);
    p.by2 = coord_t'(by2);
    return p;
  endfunction

  function automatic int any_coord();
    return int'(coord_t'($urandom_range(4095)));
  endfunction

  function automatic int near(int center, int span);
    return center + $signed($urandom_range(2 * span)) - span;
  endfunction

  // Hand-picked pairs: extreme coordinates, parallel and collinear lines,
  // degenerate point segments, crossings on endpoints, and near misses.
  task automatic test_directed();
    send_pair(make_pair(-2048, -2048, 2047, 2047, -2048, 2047, 2047, -2048));
    send_pair(make_pair(2047, 2047, -2048, -2048, 2047, -2048, -2048, 2047));
    send_pair(make_pair(-2048, 0, 2047, 0, 0, -2048, 0, 2047));
    send_pair(make_pair(0, 0, 100, 0, 0, 10, 100, 10));        // parallel
    send_pair(make_pair(0, 0, 100, 100, 50, 50, 200, 200));    // collinear overlap
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));              // all zero
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));            // point segment
    send_pair(make_pair(0, 0, 100, 0, 100, -50, 100, 50));     // touches A's end
    send_pair(make_pair(0, 0, 100, 0, 0, -50, 0, 50));         // touches A's start
    send_pair(make_pair(0, 0, 100, 0, 50, 0, 50, 50));         // touches B's start
    send_pair(make_pair(0, 0, 100, 0, 50, 50, 50, 0));         // touches B's end
    send_pair(make_pair(0, 0, 100, 0, 101, -50, 101, 50));     // just past A
    send_pair(make_pair(0, 0, 100, 0, 50, 1, 50, 50));         // just short of B
    send_pair(make_pair(0, 0, -7, -3, 3, -9, -9, 4));          // negative, rounding
    send_pair(make_pair(-1, -1, -3, -2, -2, 0, -2, -3));
    send_pair(make_pair(2047, -2048, -2048, 2047, -2048, -2048, 2047, 2047));
    send_pair(make_pair(-2048, -2048, -2048, 2047, 2047, 0, -2048, 1));
    send_pair(make_pair(1, 0, 3, 7, 0, 5, 4, 0));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(make_pair(2047, 2047, 2047, 2047, -2048, -2048, -2048, -2048));
  endtask

  // Random pairs, half of them built to cross so that the hit path is well exercised.
  task automatic test_random(int count);
    seg_pair_t p;
    int px, py, ax, ay, bx, by, ox, oy;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          // Both segments are mirrored about a common point and pass through it unless an endpoint wraps.
          px = near(0, 500);
          py = near(0, 500);
          ax = near(px, 1000);
          ay = near(py, 1000);
          bx = near(px, 1000);
          by = near(py, 1000);
          p  = make_pair(ax, ay, 2 * px - ax, 2 * py - ay,
                         bx, by, 2 * px - bx, 2 * py - by);
        end
        5, 6: begin
          p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                        any_coord(), any_coord(), any_coord(), any_coord());
        end
        7: begin
          // Parallel copy of A, shifted.
          ax = near(0, 900);
          ay = near(0, 900);
          px = near(ax, 900);
          py = near(ay, 900);
          ox = near(0, 200);
          oy = near(0, 200);
          p  = make_pair(ax, ay, px, py, ax + ox, ay + oy, px + ox, py + oy);
        end
        default: begin
          // Tiny segments, where truncation and the floor shift matter most.
          px = near(0, 2000);
          py = near(0, 2000);
          p  = make_pair(px, py, near(px, 4), near(py, 4),
                         near(px, 4), near(py, 4), near(px, 4), near(py, 4));
        end
      endcase
      send_pair(p);
    end
  endtask

  // Lets the pipeline empty, then a little longer to catch stray strobes.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  initial begin
    error_count     = 0;
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    seg_a_x1_i      = '0;
    seg_a_y1_i      = '0;
    seg_a_x2_i      = '0;
    seg_a_y2_i      = '0;
    seg_b_x1_i      = '0;
    seg_b_y1_i      = '0;
    seg_b_x2_i      = '0;
    seg_b_y2_i      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 30;
    test_directed();
    test_random(280);
    sender_idle_pct = 55;
    test_random(280);
    sender_idle_pct = 0;
    test_random(290);
    drain_pipeline();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sif_pkg.sv
hdl/sif_divider.sv
hdl/segment_intersection_fixed_core.sv
test/segment_intersection_fixed_core_tb.sv
